### hw/rtl/spq_pkg.sv
package spq_pkg;

	localparam int VAL_W        = 32;
	localparam int CNT_OUT_W    = 5;
	localparam int CAPACITY_DEF = 16;

	typedef logic [1:0] op_t;

	localparam op_t OP_INSERT = 2'd0;
	localparam op_t OP_REMOVE = 2'd1;
	localparam op_t OP_CLEAR  = 2'd2;

	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;

endpackage

### hw/rtl/spq_if.sv
interface spq_req_if
	import spq_pkg::*;
	;
	logic                    valid;
	logic                    ready;
	op_t                     op;
	logic signed [VAL_W-1:0] value;

	modport source (output valid, output op, output value, input ready);
	modport sink   (input valid, input op, input value, output ready);
endinterface

interface spq_rsp_if
	import spq_pkg::*;
	;
	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] smallest;
	logic [CNT_OUT_W-1:0]    entry_count;
	logic                    is_empty;
	logic                    is_full;
	logic                    error;

	modport source (output valid, output smallest, output entry_count, output is_empty,
		output is_full, output error, input ready);
	modport sink   (input valid, input smallest, input entry_count, input is_empty,
		input is_full, input error, output ready);
endinterface

### hw/rtl/spq_ctrl.sv
module spq_ctrl
	import spq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	output logic rsp_valid,
	input  logic rsp_ready,
	output cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   rsp_valid_q;

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.exec = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

### hw/rtl/spq_dp.sv
module spq_dp
	import spq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cmd_t                    cmd,
	input  op_t                     req_op,
	input  logic signed [VAL_W-1:0] req_value,
	output logic signed [VAL_W-1:0] smallest,
	output logic [CNT_OUT_W-1:0]    entry_count,
	output logic                    is_empty,
	output logic                    is_full,
	output logic                    error
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int EW = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;

	op_t                     op_q;
	logic signed [VAL_W-1:0] value_q;
	logic signed [VAL_W-1:0] cells_q [CAPACITY];
	logic signed [VAL_W-1:0] cells_d [CAPACITY];
	logic [CW-1:0]           cnt_q;
	logic [CW-1:0]           cnt_d;
	logic [CAPACITY-1:0]     less;
	logic [CAPACITY:0]       lt_up;
	logic                    full;
	logic                    ins_ok;
	logic                    rem_ok;
	logic                    err_d;
	logic signed [VAL_W-1:0] head_d;
	logic [EW-1:0]           cnt_ext;

	assign full   = (cnt_q == CW'(CAPACITY));
	assign ins_ok = (op_q == OP_INSERT) && !full;
	assign rem_ok = (op_q == OP_REMOVE) && (cnt_q != '0);
	assign err_d  = ((op_q == OP_INSERT) && full) || ((op_q == OP_REMOVE) && (cnt_q == '0));

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			less[i] = (CW'(i) < cnt_q) && (cells_q[i] < value_q);
		end
		lt_up = {less, 1'b1};
	end

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			if (op_q == OP_REMOVE) begin
				cells_d[i] = cells_q[(i == CAPACITY - 1) ? i : i + 1];
			end else if (less[i]) begin
				cells_d[i] = cells_q[i];
			end else if (lt_up[i]) begin
				cells_d[i] = value_q;
			end else begin
				cells_d[i] = cells_q[(i == 0) ? 0 : i - 1];
			end
		end
	end

	always_comb begin
		priority if (ins_ok) begin
			cnt_d = cnt_q + CW'(1);
		end else if (rem_ok) begin
			cnt_d = cnt_q - CW'(1);
		end else if (op_q == OP_CLEAR) begin
			cnt_d = '0;
		end else begin
			cnt_d = cnt_q;
		end
	end

	assign head_d  = (ins_ok || rem_ok) ? cells_d[0] : cells_q[0];
	assign cnt_ext = EW'(cnt_d);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= req_op;
			value_q <= req_value;
		end
		if (cmd.exec && (ins_ok || rem_ok)) begin
			cells_q <= cells_d;
		end
		if (cmd.exec) begin
			smallest    <= (cnt_d != '0) ? head_d : '0;
			entry_count <= cnt_ext[CNT_OUT_W-1:0];
			is_empty    <= (cnt_d == '0);
			is_full     <= (cnt_d == CW'(CAPACITY));
			error       <= err_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.exec) begin
			cnt_q <= cnt_d;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_full_insert_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && (op_q == OP_INSERT) && full |=> $stable(cnt_q) && error)
		else $error("insert into full store changed the count");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && (op_q == OP_CLEAR) |=> (cnt_q == '0) && is_empty && !error)
		else $error("clear left entries behind");

endmodule

### hw/rtl/sorted_insert_priority_queue_core.sv
// Sorted priority queue of up to CAPACITY signed 32-bit values, kept ascending in a row of
// compare-and-shift cells. Each request (insert, remove smallest, clear) yields one response
// with the smallest value, the entry count (low 5 bits), empty/full flags and an error flag;
// a failed insert or remove leaves the store untouched. A request is first captured; in
// the execute state all cells compare against the new value and shift in parallel and
// the response register loads. No request is taken until the last has executed, but one is
// taken while an earlier response waits on rsp.ready; a stalled response holds the update.
module sorted_insert_priority_queue_core
	import spq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	spq_req_if.sink   req,
	spq_rsp_if.source rsp
);

	cmd_t cmd;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd)
	);

	spq_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.req_op      (req.op),
		.req_value   (req.value),
		.smallest    (rsp.smallest),
		.entry_count (rsp.entry_count),
		.is_empty    (rsp.is_empty),
		.is_full     (rsp.is_full),
		.error       (rsp.error)
	);

endmodule
